@@ src/dssc_pkg.sv @@
package dssc_pkg;

    // Number of right steps made on each motor while homing after reset.
    localparam logic [7:0] HOME_STEPS = 8'd2;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [2:0] REG_OPC_M1_RIGHT = 3'd0;
    localparam logic [2:0] REG_OPC_M1_LEFT  = 3'd1;
    localparam logic [2:0] REG_OPC_M2_RIGHT = 3'd2;
    localparam logic [2:0] REG_OPC_M2_LEFT  = 3'd3;
    localparam logic [2:0] REG_STEP_WAIT    = 3'd4;
    localparam logic [2:0] REG_SETTLE_WAIT  = 3'd5;
    localparam logic [2:0] REG_HOME_WAIT    = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_OPC_M1_RIGHT = 8'd1;
    localparam logic [7:0]  RST_OPC_M1_LEFT  = 8'd2;
    localparam logic [7:0]  RST_OPC_M2_RIGHT = 8'd3;
    localparam logic [7:0]  RST_OPC_M2_LEFT  = 8'd4;
    localparam logic [15:0] RST_STEP_WAIT    = 16'd5;
    localparam logic [15:0] RST_SETTLE_WAIT  = 16'd500;
    localparam logic [15:0] RST_HOME_WAIT    = 16'd100;

    // Reset value of both coil patterns.
    localparam logic [7:0] PATTERN_RESET = 8'hCC;

    // Motor and direction codes.
    localparam logic MOTOR_ONE = 1'b0;
    localparam logic MOTOR_TWO = 1'b1;
    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_LEFT  = 1'b1;

    // Item kinds on the input stream.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_HOME1  = 3'd0,
        ST_HOME2  = 3'd1,
        ST_IDLE   = 3'd2,
        ST_HIGH   = 3'd3,
        ST_LOW    = 3'd4,
        ST_MOVE   = 3'd5,
        ST_SETTLE = 3'd6
    } t_seq_state;

    // Configuration register contents as seen by the sequencer.
    typedef struct packed {
        logic [7:0]  opc_m1_right;
        logic [7:0]  opc_m1_left;
        logic [7:0]  opc_m2_right;
        logic [7:0]  opc_m2_left;
        logic [15:0] step_wait;
        logic [15:0] settle_wait;
        logic [15:0] home_wait;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic       busy;
        logic       ack;
        logic [1:0] phase_two;
        logic [1:0] phase_one;
    } t_result;

endpackage

@@ src/dssc_cfg.sv @@
module dssc_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output dssc_pkg::t_cfg      o_cfg
);

    dssc_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [2:0]     w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.opc_m1_right <= dssc_pkg::RST_OPC_M1_RIGHT;
            r_cfg.opc_m1_left  <= dssc_pkg::RST_OPC_M1_LEFT;
            r_cfg.opc_m2_right <= dssc_pkg::RST_OPC_M2_RIGHT;
            r_cfg.opc_m2_left  <= dssc_pkg::RST_OPC_M2_LEFT;
            r_cfg.step_wait    <= dssc_pkg::RST_STEP_WAIT;
            r_cfg.settle_wait  <= dssc_pkg::RST_SETTLE_WAIT;
            r_cfg.home_wait    <= dssc_pkg::RST_HOME_WAIT;
        end else if (w_wr) begin
            unique case (w_idx)
                dssc_pkg::REG_OPC_M1_RIGHT: r_cfg.opc_m1_right <= pwdata[7:0];
                dssc_pkg::REG_OPC_M1_LEFT:  r_cfg.opc_m1_left  <= pwdata[7:0];
                dssc_pkg::REG_OPC_M2_RIGHT: r_cfg.opc_m2_right <= pwdata[7:0];
                dssc_pkg::REG_OPC_M2_LEFT:  r_cfg.opc_m2_left  <= pwdata[7:0];
                dssc_pkg::REG_STEP_WAIT:    r_cfg.step_wait    <= pwdata[15:0];
                dssc_pkg::REG_SETTLE_WAIT:  r_cfg.settle_wait  <= pwdata[15:0];
                dssc_pkg::REG_HOME_WAIT:    r_cfg.home_wait    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            dssc_pkg::REG_OPC_M1_RIGHT: prdata = {24'd0, r_cfg.opc_m1_right};
            dssc_pkg::REG_OPC_M1_LEFT:  prdata = {24'd0, r_cfg.opc_m1_left};
            dssc_pkg::REG_OPC_M2_RIGHT: prdata = {24'd0, r_cfg.opc_m2_right};
            dssc_pkg::REG_OPC_M2_LEFT:  prdata = {24'd0, r_cfg.opc_m2_left};
            dssc_pkg::REG_STEP_WAIT:    prdata = {16'd0, r_cfg.step_wait};
            dssc_pkg::REG_SETTLE_WAIT:  prdata = {16'd0, r_cfg.settle_wait};
            dssc_pkg::REG_HOME_WAIT:    prdata = {16'd0, r_cfg.home_wait};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

@@ src/dssc_seq.sv @@
module dssc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_kind,
    input  logic [7:0]          i_byte,
    input  dssc_pkg::t_cfg      i_cfg,
    output dssc_pkg::t_result   o_result
);

    dssc_pkg::t_seq_state r_state, n_state;
    logic [7:0]  r_pat_one, n_pat_one;
    logic [7:0]  r_pat_two, n_pat_two;
    logic [1:0]  r_phase_one, n_phase_one;
    logic [1:0]  r_phase_two, n_phase_two;
    logic [15:0] r_steps, n_steps;
    logic [15:0] r_wait, n_wait;
    logic [7:0]  r_high, n_high;
    logic        r_motor, n_motor;
    logic        r_dir, n_dir;

    logic        w_timed;
    logic        w_wait_done;
    logic        w_step;
    logic        w_step_motor;
    logic        w_step_dir;
    logic        w_ack;
    logic [15:0] w_wait_dec;
    logic [15:0] w_count;
    logic [7:0]  w_pat_sel;
    logic [7:0]  w_pat_rot;

    function automatic logic is_timed(input dssc_pkg::t_seq_state s);
        return (s == dssc_pkg::ST_HOME1) || (s == dssc_pkg::ST_HOME2) ||
               (s == dssc_pkg::ST_MOVE)  || (s == dssc_pkg::ST_SETTLE);
    endfunction

    function automatic logic is_stepping(input dssc_pkg::t_seq_state s);
        return (s == dssc_pkg::ST_HOME1) || (s == dssc_pkg::ST_HOME2) ||
               (s == dssc_pkg::ST_MOVE);
    endfunction

    // Step count is high * 255 + low, formed as high * 256 - high + low.
    assign w_count = ({r_high, 8'h00} - {8'h00, r_high}) + {8'h00, i_byte};
    assign w_timed = is_timed(r_state);
    assign w_wait_dec = (r_wait == 16'd0) ? 16'd0 : r_wait - 16'd1;

    // Next state: decode the item, then finish the current wait if it ran out.
    always_comb begin
        n_state      = r_state;
        n_steps      = r_steps;
        n_wait       = r_wait;
        n_high       = r_high;
        n_motor      = r_motor;
        n_dir        = r_dir;
        w_wait_done  = 1'b0;
        w_step       = 1'b0;
        w_step_motor = r_motor;
        w_step_dir   = r_dir;
        w_ack        = 1'b0;

        if (i_fire) begin
            if (i_kind == dssc_pkg::KIND_TICK) begin
                if (w_timed) begin
                    n_wait = w_wait_dec;
                    w_wait_done = (w_wait_dec == 16'd0);
                end
            end else if (!w_timed) begin
                unique case (r_state)
                    dssc_pkg::ST_HIGH: begin
                        n_high  = i_byte;
                        n_state = dssc_pkg::ST_LOW;
                    end
                    dssc_pkg::ST_LOW: begin
                        n_steps     = w_count;
                        n_state     = dssc_pkg::ST_MOVE;
                        n_wait      = 16'd0;
                        w_wait_done = 1'b1;
                    end
                    default: begin
                        // Opcode byte: first matching register wins.
                        n_state = dssc_pkg::ST_HIGH;
                        if (i_byte == i_cfg.opc_m1_right) begin
                            n_motor = dssc_pkg::MOTOR_ONE;
                            n_dir   = dssc_pkg::DIR_RIGHT;
                        end else if (i_byte == i_cfg.opc_m1_left) begin
                            n_motor = dssc_pkg::MOTOR_ONE;
                            n_dir   = dssc_pkg::DIR_LEFT;
                        end else if (i_byte == i_cfg.opc_m2_right) begin
                            n_motor = dssc_pkg::MOTOR_TWO;
                            n_dir   = dssc_pkg::DIR_RIGHT;
                        end else if (i_byte == i_cfg.opc_m2_left) begin
                            n_motor = dssc_pkg::MOTOR_TWO;
                            n_dir   = dssc_pkg::DIR_LEFT;
                        end else begin
                            n_state = dssc_pkg::ST_SETTLE;
                            n_wait  = i_cfg.settle_wait;
                        end
                    end
                endcase
            end
        end

        if (w_wait_done) begin
            if (is_stepping(n_state) && (n_steps != 16'd0)) begin
                // Next step of the current run.
                w_step       = 1'b1;
                w_step_motor = n_motor;
                w_step_dir   = n_dir;
                n_steps      = n_steps - 16'd1;
                n_wait       = (n_state == dssc_pkg::ST_MOVE) ? i_cfg.step_wait
                                                              : i_cfg.home_wait;
            end else begin
                unique case (n_state)
                    dssc_pkg::ST_HOME1: begin
                        // Motor one homed: start homing motor two at once.
                        n_state = dssc_pkg::ST_HOME2;
                        n_motor = dssc_pkg::MOTOR_TWO;
                        n_dir   = dssc_pkg::DIR_RIGHT;
                        if (dssc_pkg::HOME_STEPS != 8'd0) begin
                            w_step       = 1'b1;
                            w_step_motor = dssc_pkg::MOTOR_TWO;
                            w_step_dir   = dssc_pkg::DIR_RIGHT;
                            n_steps      = {8'd0, dssc_pkg::HOME_STEPS} - 16'd1;
                            n_wait       = i_cfg.home_wait;
                        end else begin
                            n_state = dssc_pkg::ST_IDLE;
                            n_steps = {8'd0, dssc_pkg::HOME_STEPS};
                            n_wait  = 16'd0;
                        end
                    end
                    dssc_pkg::ST_HOME2: n_state = dssc_pkg::ST_IDLE;
                    dssc_pkg::ST_MOVE: begin
                        n_state = dssc_pkg::ST_SETTLE;
                        n_wait  = i_cfg.settle_wait;
                    end
                    dssc_pkg::ST_SETTLE: begin
                        w_ack   = 1'b1;
                        n_state = dssc_pkg::ST_IDLE;
                    end
                    default: n_state = dssc_pkg::ST_IDLE;
                endcase
            end
        end
    end

    // Pattern rotation of the stepping motor and the phase load.
    assign w_pat_sel = (w_step_motor == dssc_pkg::MOTOR_ONE) ? r_pat_one : r_pat_two;
    assign w_pat_rot = (w_step_dir == dssc_pkg::DIR_RIGHT) ?
                       {w_pat_sel[0], w_pat_sel[7:1]} : {w_pat_sel[6:0], w_pat_sel[7]};

    always_comb begin
        n_pat_one   = r_pat_one;
        n_pat_two   = r_pat_two;
        n_phase_one = r_phase_one;
        n_phase_two = r_phase_two;
        if (w_step) begin
            if (w_step_motor == dssc_pkg::MOTOR_ONE) begin
                n_pat_one   = w_pat_rot;
                n_phase_one = w_pat_rot[7:6];
            end else begin
                n_pat_two   = w_pat_rot;
                n_phase_two = w_pat_rot[7:6];
            end
        end
    end

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dssc_pkg::ST_HOME1;
            r_pat_one   <= dssc_pkg::PATTERN_RESET;
            r_pat_two   <= dssc_pkg::PATTERN_RESET;
            r_phase_one <= 2'd0;
            r_phase_two <= 2'd0;
            r_steps     <= {8'd0, dssc_pkg::HOME_STEPS};
            r_wait      <= 16'd0;
            r_high      <= 8'd0;
            r_motor     <= dssc_pkg::MOTOR_ONE;
            r_dir       <= dssc_pkg::DIR_RIGHT;
        end else begin
            r_state     <= n_state;
            r_pat_one   <= n_pat_one;
            r_pat_two   <= n_pat_two;
            r_phase_one <= n_phase_one;
            r_phase_two <= n_phase_two;
            r_steps     <= n_steps;
            r_wait      <= n_wait;
            r_high      <= n_high;
            r_motor     <= n_motor;
            r_dir       <= n_dir;
        end
    end

    // Result reflects the state after this item.
    assign o_result.phase_one = n_phase_one;
    assign o_result.phase_two = n_phase_two;
    assign o_result.ack       = w_ack;
    assign o_result.busy      = is_timed(n_state);

endmodule

@@ src/dual_stepper_command_sequencer.sv @@
// Dual stepper command sequencer. Items arrive on the slave stream: a received
// command byte (tuser = 0) or one timer tick (tuser = 1). Every item gives
// exactly one result item with both motors' coil phases, an acknowledge flag
// and a busy flag. After reset each motor is homed with two right steps; a
// command is an opcode byte followed by high and low count bytes, and bytes
// arriving while busy are dropped. The block takes one item per clock cycle
// while the output side is not stalled; an item is held in the input
// register, then passes through the sequencer logic into the output register.
// The output register lets a new item be taken while a result waits to be
// read. Configuration registers sit on the APB port at byte address 4 * index
// and should be written only while the block is idle. No clearing pass is
// needed after reset.
module dual_stepper_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] kind
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] motor_one_phase, [3:2] motor_two_phase,
                                        // [4] ack_pulse, [5] busy_res, [7:6] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dssc_pkg::t_cfg    w_cfg;
    dssc_pkg::t_result w_result;

    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       w_out_adv;
    logic       w_fire;
    logic       w_in_take;

    // Pipeline advance: the output register frees up when empty or read.
    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_adv;
    assign s_axis_tready = !r_in_valid || w_out_adv;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    dssc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dssc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {2'b00, w_result.busy, w_result.ack,
                           w_result.phase_two, w_result.phase_one};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ src/dssc_checker.sv @@
module dssc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // The input side only stalls when the output side is full and stalled.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // An acknowledge always comes with the block going idle.
    a_ack_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[5])
        else $error("acknowledge flagged while still busy");

    // Padding bits of a result are zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:6] == 2'b00))
        else $error("result padding bits not zero");

endmodule

bind dual_stepper_command_sequencer dssc_checker u_dssc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
